// File: rtl/ccorr_pkg.sv
// ----------------------------------------------------------------------------
// ccorr_pkg
// Types, widths and codes shared by the complex cross correlator.
// ----------------------------------------------------------------------------
package ccorr_pkg;

    localparam int REF_LEN     = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int SLOT_W      = 6;
    localparam int LEN_W       = 7;
    localparam int ACC_W       = 2 * SAMPLE_BITS + SLOT_W + 1;
    localparam int MAG_W       = ACC_W - 1;
    localparam int EN_W        = 2 * SAMPLE_BITS + SLOT_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int RAT_W       = 32;
    localparam int FRAC_W      = 16;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_DATA    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]                    mode;
        logic [SLOT_W-1:0]             ref_slot;
        logic signed [SAMPLE_BITS-1:0] sample_i;
        logic signed [SAMPLE_BITS-1:0] sample_q;
    } t_in;

    typedef struct packed {
        logic [31:0]      lag;
        logic [RAT_W-1:0] ratio;
        logic             zero_power;
    } t_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ISSUE,
        OP_SQA,
        OP_SQB,
        OP_SQRT,
        OP_DIVCHK,
        OP_DIV,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic              accept;
        t_op               op;
        logic [SLOT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] n_last;
    } t_sts;

endpackage

// File: rtl/ccorr_ram.sv
// ----------------------------------------------------------------------------
// ccorr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccorr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ccorr_ctrl.sv
// ----------------------------------------------------------------------------
// ccorr_ctrl
// Sequencer: correlation sweep, squaring, square root, division, output.
// ----------------------------------------------------------------------------
module ccorr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_stall,
    output logic            o_valid,
    input  ccorr_pkg::t_sts i_sts,
    output ccorr_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORR,
        ST_DRAIN,
        ST_SQA,
        ST_SQB,
        ST_SQRT,
        ST_DIVCHK,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam logic [ccorr_pkg::SLOT_W-1:0] MAG_LAST =
        ccorr_pkg::SLOT_W'(ccorr_pkg::MAG_W - 1);
    localparam logic [ccorr_pkg::SLOT_W-1:0] DIV_LAST =
        ccorr_pkg::SLOT_W'(ccorr_pkg::RAT_W - 1);

    t_state                        r_state;
    logic [ccorr_pkg::SLOT_W-1:0]  r_cnt;
    logic                          r_o_valid;
    logic                          w_accept;
    logic                          w_out_free;

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_o_valid;
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;

    always_comb begin
        o_cmd.accept = w_accept;
        o_cmd.idx    = r_cnt;
        unique case (r_state)
            ST_CORR:   o_cmd.op = ccorr_pkg::OP_ISSUE;
            ST_SQA:    o_cmd.op = ccorr_pkg::OP_SQA;
            ST_SQB:    o_cmd.op = ccorr_pkg::OP_SQB;
            ST_SQRT:   o_cmd.op = ccorr_pkg::OP_SQRT;
            ST_DIVCHK: o_cmd.op = ccorr_pkg::OP_DIVCHK;
            ST_DIV:    o_cmd.op = ccorr_pkg::OP_DIV;
            ST_OUT:    o_cmd.op = w_out_free ? ccorr_pkg::OP_OUT : ccorr_pkg::OP_NONE;
            default:   o_cmd.op = ccorr_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && i_sts.start) begin
                        r_state <= ST_CORR;
                    end
                end
                ST_CORR: begin
                    if (r_cnt == i_sts.n_last) begin
                        r_cnt   <= '0;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (r_cnt == ccorr_pkg::SLOT_W'(1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_SQA;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQA: begin
                    if (r_cnt == MAG_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_SQB;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQB: begin
                    if (r_cnt == MAG_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (r_cnt == MAG_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_DIVCHK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DIVCHK: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        r_cnt   <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/ccorr_dp.sv
// ----------------------------------------------------------------------------
// ccorr_dp
// Datapath: reference and window stores, multiply-accumulate, serial
// squaring, digit-by-digit square root and restoring division.
// ----------------------------------------------------------------------------
module ccorr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ccorr_pkg::t_in                    i_in,
    input  logic                              i_cfg_wr_en,
    input  logic [ccorr_pkg::LEN_W-1:0]       i_cfg_wr_data,
    input  ccorr_pkg::t_cmd                   i_cmd,
    output ccorr_pkg::t_sts                   o_sts,
    output ccorr_pkg::t_out                   o_out
);

    localparam int SB  = ccorr_pkg::SAMPLE_BITS;
    localparam int SW  = ccorr_pkg::SLOT_W;
    localparam int LW  = ccorr_pkg::LEN_W;
    localparam int AW  = ccorr_pkg::ACC_W;
    localparam int MW  = ccorr_pkg::MAG_W;
    localparam int EW  = ccorr_pkg::EN_W;
    localparam int QW  = ccorr_pkg::SQ_W;
    localparam int RW  = ccorr_pkg::RAT_W;
    localparam int FW  = ccorr_pkg::FRAC_W;

    logic [LW-1:0]        r_ref_len;
    logic [LW-1:0]        r_fill;
    logic [SW-1:0]        r_wp;
    logic [SW-1:0]        r_base;
    logic [31:0]          r_lag;
    logic                 r_ref_vld [ccorr_pkg::REF_LEN];
    logic                 r_rv;
    logic                 r_v1;
    logic                 r_v2;

    logic [LW-1:0]        w_n;
    logic [LW-1:0]        w_fill_nx;
    logic                 w_load;
    logic                 w_data;
    logic [2*SB-1:0]      w_ref_rd;
    logic [2*SB-1:0]      w_win_rd;

    logic signed [SB-1:0]   w_ri;
    logic signed [SB-1:0]   w_rq;
    logic signed [SB-1:0]   w_di;
    logic signed [SB-1:0]   w_dq;
    logic signed [2*SB-1:0] r_pii;
    logic signed [2*SB-1:0] r_pqq;
    logic signed [2*SB-1:0] r_pqi;
    logic signed [2*SB-1:0] r_piq;
    logic [2*SB-1:0]        r_ei;
    logic [2*SB-1:0]        r_eq;

    logic signed [AW-1:0] r_re;
    logic signed [AW-1:0] r_im;
    logic [EW-1:0]        r_en;
    logic [MW-1:0]        w_abs_re;
    logic [MW-1:0]        w_abs_im;
    logic [MW-1:0]        w_sq_op;
    logic [QW-1:0]        r_sq;

    logic [MW+1:0]        r_rem;
    logic [MW-1:0]        r_root;
    logic [MW+3:0]        w_rem_nx;
    logic [MW+3:0]        w_trial;

    logic [EW-1:0]        r_drem;
    logic [RW-1:0]        r_dvd;
    logic [RW-1:0]        r_q;
    logic                 r_sat;
    logic                 r_zero;
    logic [EW:0]          w_dt;

    always_comb begin
        priority if (r_ref_len == '0) begin
            w_n = LW'(1);
        end else if (r_ref_len > LW'(ccorr_pkg::REF_LEN)) begin
            w_n = LW'(ccorr_pkg::REF_LEN);
        end else begin
            w_n = r_ref_len;
        end
    end

    assign w_fill_nx = (r_fill < LW'(ccorr_pkg::REF_LEN)) ? r_fill + 1'b1 : r_fill;
    assign w_load    = i_cmd.accept && (i_in.mode == ccorr_pkg::MODE_LOAD) &&
                       ({1'b0, i_in.ref_slot} < LW'(ccorr_pkg::REF_LEN));
    assign w_data    = i_cmd.accept && (i_in.mode == ccorr_pkg::MODE_DATA);

    assign o_sts.start  = (i_in.mode == ccorr_pkg::MODE_DATA) && (w_fill_nx >= w_n);
    assign o_sts.n_last = SW'(w_n - 1'b1);

    ccorr_ram #(.WIDTH(2 * SB), .DEPTH(ccorr_pkg::REF_LEN)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_in.ref_slot),
        .i_wdata ({i_in.sample_i, i_in.sample_q}),
        .i_raddr (i_cmd.idx),
        .o_rdata (w_ref_rd)
    );

    ccorr_ram #(.WIDTH(2 * SB), .DEPTH(ccorr_pkg::REF_LEN)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (w_data),
        .i_waddr (r_wp),
        .i_wdata ({i_in.sample_i, i_in.sample_q}),
        .i_raddr (r_base + i_cmd.idx),
        .o_rdata (w_win_rd)
    );

    // unwritten reference slots read as zero
    assign w_ri = r_rv ? w_ref_rd[2*SB-1:SB] : '0;
    assign w_rq = r_rv ? w_ref_rd[SB-1:0]    : '0;
    assign w_di = w_win_rd[2*SB-1:SB];
    assign w_dq = w_win_rd[SB-1:0];

    assign w_abs_re = r_re[AW-1] ? MW'(-r_re) : MW'(r_re);
    assign w_abs_im = r_im[AW-1] ? MW'(-r_im) : MW'(r_im);
    assign w_sq_op  = (i_cmd.op == ccorr_pkg::OP_SQB) ? w_abs_im : w_abs_re;

    assign w_rem_nx = {r_rem, r_sq[QW-1:QW-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_dt     = {r_drem, r_dvd[RW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len <= LW'(64);
            r_fill    <= '0;
            r_wp      <= '0;
            r_lag     <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            for (int k = 0; k < ccorr_pkg::REF_LEN; k++) begin
                r_ref_vld[k] <= 1'b0;
            end
        end else begin
            r_v1 <= (i_cmd.op == ccorr_pkg::OP_ISSUE);
            r_v2 <= r_v1;
            if (i_cfg_wr_en) begin
                r_ref_len <= i_cfg_wr_data;
            end
            if (w_load) begin
                r_ref_vld[i_in.ref_slot] <= 1'b1;
            end
            if (w_data) begin
                r_wp   <= r_wp + 1'b1;
                r_fill <= w_fill_nx;
            end
            if (i_cmd.accept && (i_in.mode == ccorr_pkg::MODE_RESTART)) begin
                r_fill <= '0;
                r_lag  <= '0;
            end
            if (i_cmd.op == ccorr_pkg::OP_OUT) begin
                r_lag <= r_lag + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data) begin
            r_base <= r_wp - o_sts.n_last;
            r_re   <= '0;
            r_im   <= '0;
            r_en   <= '0;
            r_sq   <= '0;
            r_rem  <= '0;
            r_root <= '0;
        end
        r_rv <= r_ref_vld[i_cmd.idx];
        if (r_v1) begin
            r_pii <= w_di * w_ri;
            r_pqq <= w_dq * w_rq;
            r_pqi <= w_dq * w_ri;
            r_piq <= w_di * w_rq;
            r_ei  <= w_ri * w_ri;
            r_eq  <= w_rq * w_rq;
        end
        if (r_v2) begin
            // multiply by the conjugate of the reference: (di + j dq) * (ri - j rq)
            r_re <= r_re + AW'(r_pii) + AW'(r_pqq);
            r_im <= r_im + AW'(r_pqi) - AW'(r_piq);
            r_en <= r_en + EW'(r_ei) + EW'(r_eq);
        end
        unique case (i_cmd.op)
            ccorr_pkg::OP_SQA, ccorr_pkg::OP_SQB: begin
                if (w_sq_op[i_cmd.idx]) begin
                    r_sq <= r_sq + ({{MW{1'b0}}, w_sq_op} << i_cmd.idx);
                end
            end
            ccorr_pkg::OP_SQRT: begin
                r_sq <= {r_sq[QW-3:0], 2'b00};
                if (w_rem_nx >= w_trial) begin
                    r_rem  <= (MW+2)'(w_rem_nx - w_trial);
                    r_root <= {r_root[MW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_nx[MW+1:0];
                    r_root <= {r_root[MW-2:0], 1'b0};
                end
            end
            ccorr_pkg::OP_DIVCHK: begin
                r_zero <= (r_en == '0);
                r_sat  <= (EW'(r_root[MW-1:FW]) >= r_en);
                r_drem <= EW'(r_root[MW-1:FW]);
                r_dvd  <= {r_root[FW-1:0], {(RW-FW){1'b0}}};
                r_q    <= '0;
            end
            ccorr_pkg::OP_DIV: begin
                r_dvd <= {r_dvd[RW-2:0], 1'b0};
                if (w_dt >= {1'b0, r_en}) begin
                    r_drem <= EW'(w_dt - {1'b0, r_en});
                    r_q    <= {r_q[RW-2:0], 1'b1};
                end else begin
                    r_drem <= w_dt[EW-1:0];
                    r_q    <= {r_q[RW-2:0], 1'b0};
                end
            end
            ccorr_pkg::OP_OUT: begin
                o_out.lag        <= r_lag;
                o_out.ratio      <= (r_zero || r_sat) ? '1 : r_q;
                o_out.zero_power <= r_zero;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/complex_cross_correlator.sv
// ----------------------------------------------------------------------------
// complex_cross_correlator
// Matched-filter correlator of complex IQ samples against a stored reference.
// ----------------------------------------------------------------------------
// Load, restart and data items that do not fill the window leave the block
// idle. A data item that yields a result starts a sweep through the two
// sample memories over the active reference length, then runs serial
// squaring, square root and division before the result is output.
// One item is in work at a time; a finished beat waits in the output register.
// Synchronous active-low reset; stores need no clearing pass.
module complex_cross_correlator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  ccorr_pkg::t_in              i_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output ccorr_pkg::t_out             o_out,
    input  logic                        i_cfg_wr_en,
    input  logic [ccorr_pkg::LEN_W-1:0] i_cfg_wr_data
);

    ccorr_pkg::t_cmd w_cmd;
    ccorr_pkg::t_sts w_sts;

    ccorr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ccorr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out         (o_out)
    );

endmodule

// File: rtl/ccorr_chk.sv
// ----------------------------------------------------------------------------
// ccorr_chk
// Port-level checks of the correlator, bound to the top level.
// ----------------------------------------------------------------------------
module ccorr_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input ccorr_pkg::t_out o_out
);

    // a held beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // zero reference power always saturates the ratio
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.zero_power |-> o_out.ratio == 32'hFFFF_FFFF)
        else $error("zero power without saturated ratio");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a result never appears in the cycle right after an accepted beat
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind complex_cross_correlator ccorr_chk u_ccorr_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);

// File: tb/sv/complex_cross_correlator_test.sv
// ----------------------------------------------------------------------------
// complex_cross_correlator_test
// Self-checking bench for the complex cross correlator. A scoreboard class
// predicts every correlation beat from the accepted input beats and compares
// it field by field. The run covers directed corner cases, then random
// reference loads, restarts and data streams over a range of reference
// lengths. Both sides idle at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module complex_cross_correlator_test;

    class corr_scoreboard;
        longint          ref_i[ccorr_pkg::REF_LEN];
        longint          ref_q[ccorr_pkg::REF_LEN];
        longint          win_i[ccorr_pkg::REF_LEN];
        longint          win_q[ccorr_pkg::REF_LEN];
        longint unsigned energy;
        int              fill;
        logic [31:0]     lag;
        logic [ccorr_pkg::LEN_W-1:0] len_reg;
        ccorr_pkg::t_out expected_beats[$];
        int              errors;
        int              results;

        function new();
            for (int k = 0; k < ccorr_pkg::REF_LEN; k++) begin
                ref_i[k] = 0;
                ref_q[k] = 0;
                win_i[k] = 0;
                win_q[k] = 0;
            end
            energy = 0;
            fill = 0;
            lag = 0;
            len_reg = 7'd64;
            errors = 0;
            results = 0;
        endfunction

        function int active_len();
            if (len_reg < 1) return 1;
            if (len_reg > ccorr_pkg::REF_LEN) return ccorr_pkg::REF_LEN;
            return len_reg;
        endfunction

        function void update_energy();
            longint unsigned e;
            e = 0;
            for (int k = 0; k < active_len(); k++)
                e += ref_i[k] * ref_i[k] + ref_q[k] * ref_q[k];
            energy = e;
        endfunction

        function void set_len(logic [ccorr_pkg::LEN_W-1:0] v);
            len_reg = v;
            update_energy();
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function logic [63:0] root_of(logic [127:0] s);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] cc;
            r = 0;
            for (int b = 63; b >= 0; b--) begin
                c = r | (64'd1 << b);
                cc = {64'd0, c} * {64'd0, c};
                if (cc <= s) r = c;
            end
            return r;
        endfunction

        function void note_input(ccorr_pkg::t_in x);
            longint          si;
            longint          sq;
            longint          re;
            longint          im;
            logic [63:0]     a;
            logic [63:0]     b;
            logic [63:0]     mag;
            logic [63:0]     quo;
            logic [63:0]     rem;
            logic [15:0]     frac;
            ccorr_pkg::t_out o;
            int              n;
            si = longint'(x.sample_i);
            sq = longint'(x.sample_q);
            if (x.mode == ccorr_pkg::MODE_LOAD) begin
                ref_i[x.ref_slot] = si;
                ref_q[x.ref_slot] = -sq;
                update_energy();
                return;
            end
            if (x.mode == ccorr_pkg::MODE_RESTART) begin
                for (int k = 0; k < ccorr_pkg::REF_LEN; k++) begin
                    win_i[k] = 0;
                    win_q[k] = 0;
                end
                fill = 0;
                lag = 0;
                return;
            end
            if (x.mode != ccorr_pkg::MODE_DATA) return;
            for (int k = ccorr_pkg::REF_LEN - 1; k > 0; k--) begin
                win_i[k] = win_i[k-1];
                win_q[k] = win_q[k-1];
            end
            win_i[0] = si;
            win_q[0] = sq;
            if (fill < ccorr_pkg::REF_LEN) fill++;
            n = active_len();
            if (fill < n) return;
            re = 0;
            im = 0;
            for (int k = 0; k < n; k++) begin
                re += win_i[n-1-k] * ref_i[k] - win_q[n-1-k] * ref_q[k];
                im += win_i[n-1-k] * ref_q[k] + win_q[n-1-k] * ref_i[k];
            end
            o.lag = lag;
            o.zero_power = 1'b0;
            if (energy == 0) begin
                o.ratio = 32'hFFFF_FFFF;
                o.zero_power = 1'b1;
            end else begin
                a = (re < 0) ? -re : re;
                b = (im < 0) ? -im : im;
                mag = root_of({64'd0, a} * {64'd0, a} + {64'd0, b} * {64'd0, b});
                quo = mag / energy;
                if (quo >= 65536) begin
                    o.ratio = 32'hFFFF_FFFF;
                end else begin
                    rem = mag % energy;
                    frac = 0;
                    for (int k = 0; k < ccorr_pkg::FRAC_W; k++) begin
                        rem = rem << 1;
                        frac = frac << 1;
                        if (rem >= energy) begin
                            rem -= energy;
                            frac[0] = 1'b1;
                        end
                    end
                    o.ratio = {quo[15:0], frac};
                end
            end
            expected_beats.push_back(o);
            lag++;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check(ccorr_pkg::t_out got);
            ccorr_pkg::t_out e;
            results++;
            if (expected_beats.size() == 0) begin
                report($sformatf("unexpected beat lag=%0d", got.lag));
                return;
            end
            e = expected_beats.pop_front();
            if (got.lag !== e.lag)
                report($sformatf("lag got %0d want %0d", got.lag, e.lag));
            if (got.ratio !== e.ratio)
                report($sformatf("ratio lag %0d got %h want %h", e.lag, got.ratio, e.ratio));
            if (got.zero_power !== e.zero_power)
                report($sformatf("zero_power lag %0d got %b want %b", e.lag,
                                 got.zero_power, e.zero_power));
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    ccorr_pkg::t_in              i_in;
    logic                        o_valid;
    logic                        i_stall;
    ccorr_pkg::t_out             o_out;
    logic                        i_cfg_wr_en;
    logic [ccorr_pkg::LEN_W-1:0] i_cfg_wr_data;

    corr_scoreboard sb;
    int             items_sent;
    int             cfg_writes;
    int             stall_left;
    bit             long_hold_done;
    bit             no_idle;
    int             cur_len;

    complex_cross_correlator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in          (i_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return 16'h8000;
        if (r < 4) return 16'h7FFF;
        if (r == 4) return 16'h0000;
        return 16'($urandom);
    endfunction

    function ccorr_pkg::t_in make_beat(logic [1:0] mode, int slot);
        ccorr_pkg::t_in x;
        x.mode = mode;
        x.ref_slot = ccorr_pkg::SLOT_W'(slot);
        x.sample_i = pick_sample();
        x.sample_q = pick_sample();
        return x;
    endfunction

    function ccorr_pkg::t_in random_beat();
        int r;
        int slot;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7) slot = $urandom_range(0, cur_len - 1);
        else slot = $urandom_range(0, ccorr_pkg::REF_LEN - 1);
        if (r < 72) return make_beat(ccorr_pkg::MODE_DATA, slot);
        if (r < 86) return make_beat(ccorr_pkg::MODE_LOAD, slot);
        if (r < 93) return make_beat(ccorr_pkg::MODE_RESTART, slot);
        return make_beat(ccorr_pkg::MODE_UNUSED, slot);
    endfunction

    // called and returns at a falling edge
    task send(ccorr_pkg::t_in x);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(x);
        items_sent++;
        @(negedge i_clk);
    endtask

    task drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    task write_len(logic [ccorr_pkg::LEN_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_len(v);
        cfg_writes++;
        cur_len = (v < 1) ? 1 : ((v > ccorr_pkg::REF_LEN) ? ccorr_pkg::REF_LEN : v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task send_sample(logic [1:0] mode, int slot, logic [15:0] si, logic [15:0] sq);
        ccorr_pkg::t_in x;
        x.mode = mode;
        x.ref_slot = ccorr_pkg::SLOT_W'(slot);
        x.sample_i = si;
        x.sample_q = sq;
        send(x);
    endtask

    // output side: random stalls and one long hold
    initial begin
        i_stall = 1'b0;
        stall_left = 0;
        long_hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && sb != null && sb.results >= 150) begin
                long_hold_done = 1;
                stall_left = 3000;
            end else if (stall_left == 0 && !no_idle && $urandom_range(0, 9) < 2) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check(o_out);
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int lens[8];
        int n;
        int wait_cycles;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        items_sent = 0;
        cfg_writes = 0;
        no_idle = 0;
        cur_len = ccorr_pkg::REF_LEN;
        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero reference energy
        write_len(7'd1);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h7FFF, 16'h8000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h0001, 16'h0000);
        drain();
        write_len(7'd4);
        send_sample(ccorr_pkg::MODE_LOAD, 0, 16'h8000, 16'h8000);
        send_sample(ccorr_pkg::MODE_LOAD, 1, 16'h7FFF, 16'h7FFF);
        send_sample(ccorr_pkg::MODE_LOAD, 2, 16'h8000, 16'h7FFF);
        send_sample(ccorr_pkg::MODE_LOAD, 3, 16'h0001, 16'hFFFF);
        send_sample(ccorr_pkg::MODE_LOAD, 63, 16'h1234, 16'h8000);
        send_sample(ccorr_pkg::MODE_UNUSED, 5, 16'h7FFF, 16'h7FFF);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h8000, 16'h8000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h7FFF, 16'h8000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h8000, 16'h7FFF);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h7FFF, 16'h7FFF);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h0000, 16'h0000);
        send_sample(ccorr_pkg::MODE_RESTART, 0, 16'h0000, 16'h0000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'hFFFF, 16'h0001);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h5555, 16'hAAAA);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h8000, 16'h0000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h0000, 16'h8000);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h7FFF, 16'h0000);
        drain();
        // the window keeps its samples across a length change
        write_len(7'd127);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h7FFF, 16'h7FFF);
        drain();
        write_len(7'd0);
        send_sample(ccorr_pkg::MODE_DATA, 0, 16'h8000, 16'h8000);
        drain();

        lens = '{1, 2, 3, 4, 5, 8, 64, 127};
        while (items_sent < 850) begin
            case ($urandom_range(0, 9))
                0: write_len(7'd0);
                1: write_len(7'd64);
                2: write_len(7'($urandom_range(65, 127)));
                default: write_len(7'(lens[$urandom_range(0, 7)]));
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < cur_len; k++)
                if ($urandom_range(0, 9) < 8) send(make_beat(ccorr_pkg::MODE_LOAD, k));
            send(make_beat(ccorr_pkg::MODE_RESTART, $urandom_range(0, ccorr_pkg::REF_LEN - 1)));
            n = $urandom_range(20, 60);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 9) < 7)
                    send(make_beat(ccorr_pkg::MODE_DATA, $urandom_range(0, 63)));
                else
                    send(random_beat());
            end
            drain();
        end
        no_idle = 0;
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() > 0 && wait_cycles < 200000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(negedge i_clk);
        if (sb.pending() > 0) sb.report($sformatf("%0d beats never arrived", sb.pending()));
        $display("covered %0d input beats, %0d result beats, %0d length writes",
                 items_sent, sb.results, cfg_writes);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/ccorr_pkg.sv
rtl/ccorr_ram.sv
rtl/ccorr_ctrl.sv
rtl/ccorr_dp.sv
rtl/complex_cross_correlator.sv
rtl/ccorr_chk.sv
tb/sv/complex_cross_correlator_test.sv
